// ----- design/swsp_pkg.sv -----
// Package for the size text parser: defaults, character codes, the control
// struct that rides the multiply pipeline, and a case folding helper.
// No dependencies.
package swsp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_SUFFIX_DEF  = 7;

    // one multiply stage per power step; giga needs three
    localparam int MUL_STAGES = 3;
    localparam int STEP_W     = 2;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_CASE   = 8'h20;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_K      = 8'h6B;
    localparam logic [7:0] CH_M      = 8'h6D;

    typedef struct packed {
        logic              ok;     // text parsed, no overflow so far
        logic [STEP_W-1:0] steps;  // remaining multiplies by the base
        logic              bin;    // base 1024 instead of 1000
    } t_mul_ctl;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | CH_CASE;
        end
        return r;
    endfunction

endpackage

// ----- design/swsp_if.sv -----
// Valid/ready channel interfaces for the size text parser: one for the
// character stream, one for the results. No dependencies.
interface swsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface swsp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [63:0] byte_count;

    modport source (output valid, output valid_res, output byte_count, input ready);
    modport sink   (input valid, input valid_res, input byte_count, output ready);
endinterface

// ----- design/size_with_unit_suffix_parser_unit.sv -----
// Size text parser with unit suffix: digits, then an optional b, k, kb, ki,
// kib (and m, g forms) suffix, case-insensitive; one result per end marker.
// Depends on swsp_pkg, swsp_if, swsp_front, swsp_mul_stage.
//
// Takes one character transaction per cycle unless an end marker waits in
// the input register. Character transactions give no result. An end
// marker transaction gives its result through the input register, three
// multiply stages (one per power of the base, so giga units fit) and the
// output register. The pipeline only stalls where a full stage cannot
// drain, so characters keep flowing while a result waits at the output.
module size_with_unit_suffix_parser_unit #(
    parameter int VALUE_WIDTH = swsp_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_SUFFIX  = swsp_pkg::MAX_SUFFIX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swsp_in_if.sink    i_in,
    swsp_out_if.source o_out
);
    import swsp_pkg::*;

    logic                   st_valid [MUL_STAGES+1];
    logic                   st_ready [MUL_STAGES+1];
    t_mul_ctl               st_ctl   [MUL_STAGES+1];
    logic [VALUE_WIDTH-1:0] st_value [MUL_STAGES+1];

    logic        r_out_valid;
    logic        r_valid_res;
    logic [63:0] r_byte_count;

    swsp_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_SUFFIX  (MAX_SUFFIX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_char_code  (i_in.char_code),
        .i_end_marker (i_in.end_marker),
        .o_valid      (st_valid[0]),
        .i_ready      (st_ready[0]),
        .o_ctl        (st_ctl[0]),
        .o_value      (st_value[0])
    );

    for (genvar g = 0; g < MUL_STAGES; g++) begin : g_mul
        swsp_mul_stage #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_ctl   (st_ctl[g]),
            .i_value (st_value[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_ctl   (st_ctl[g+1]),
            .o_value (st_value[g+1])
        );
    end

    assign st_ready[MUL_STAGES] = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st_ready[MUL_STAGES]) begin
            r_out_valid <= st_valid[MUL_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_ready[MUL_STAGES] && st_valid[MUL_STAGES]) begin
            r_valid_res  <= st_ctl[MUL_STAGES].ok;
            r_byte_count <= st_ctl[MUL_STAGES].ok ?
                            64'(st_value[MUL_STAGES]) : 64'd0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.valid_res  = r_valid_res;
    assign o_out.byte_count = r_byte_count;

endmodule

// ----- design/swsp_front.sv -----
// Input register and character scanner: accumulates the decimal value,
// stores the folded suffix and decodes it on the end marker.
// Depends on swsp_pkg.
module swsp_front #(
    parameter int VALUE_WIDTH = swsp_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_SUFFIX  = swsp_pkg::MAX_SUFFIX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_char_code,
    input  logic                      i_end_marker,
    output logic                      o_valid,
    input  logic                      i_ready,
    output swsp_pkg::t_mul_ctl        o_ctl,
    output logic [VALUE_WIDTH-1:0]    o_value
);
    import swsp_pkg::*;

    localparam int LEN_W = $clog2(MAX_SUFFIX + 1);
    localparam int SUM_W = VALUE_WIDTH + 4;

    logic             r_in_valid;
    logic [7:0]       r_char;
    logic             r_end;

    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic             r_in_suffix, n_in_suffix;
    logic             r_seen, n_seen;
    logic             r_failed, n_failed;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_sfx [MAX_SUFFIX];

    logic             adv;
    logic             is_digit;
    logic             sfx_we;
    logic [7:0]       folded;
    logic [SUM_W-1:0] acc_w;
    logic [SUM_W-1:0] sum;
    logic             dec_ok;
    logic [STEP_W-1:0] dec_steps;
    logic             dec_bin;

    assign adv     = r_in_valid && (!r_end || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign o_valid = r_in_valid && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_code;
            r_end  <= i_end_marker;
        end
    end

    assign is_digit = (r_char >= CH_0) && (r_char <= CH_9);
    assign folded   = fold_case(r_char);
    assign acc_w    = {4'b0, r_acc};
    // acc * 10 + digit, digit is the low nibble of an ASCII digit
    assign sum      = (acc_w << 3) + (acc_w << 1) + {{(SUM_W-4){1'b0}}, r_char[3:0]};

    always_comb begin
        n_acc       = r_acc;
        n_in_suffix = r_in_suffix;
        n_seen      = r_seen;
        n_failed    = r_failed;
        n_len       = r_len;
        sfx_we      = 1'b0;
        if (r_end) begin
            n_acc       = '0;
            n_in_suffix = 1'b0;
            n_seen      = 1'b0;
            n_failed    = 1'b0;
            n_len       = '0;
        end else begin
            n_seen = 1'b1;
            if (!r_seen && !is_digit) begin
                n_failed = 1'b1;
            end else if (!r_failed) begin
                if (!r_in_suffix && is_digit) begin
                    if (|sum[SUM_W-1:VALUE_WIDTH]) begin
                        n_failed = 1'b1;
                    end else begin
                        n_acc = sum[VALUE_WIDTH-1:0];
                    end
                end else begin
                    n_in_suffix = 1'b1;
                    if (r_len >= LEN_W'(MAX_SUFFIX)) begin
                        n_failed = 1'b1;
                    end else begin
                        sfx_we = 1'b1;
                        n_len  = r_len + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_in_suffix <= 1'b0;
            r_seen      <= 1'b0;
            r_failed    <= 1'b0;
            r_len       <= '0;
        end else if (adv) begin
            r_acc       <= n_acc;
            r_in_suffix <= n_in_suffix;
            r_seen      <= n_seen;
            r_failed    <= n_failed;
            r_len       <= n_len;
        end
    end

    for (genvar g = 0; g < MAX_SUFFIX; g++) begin : g_sfx
        always_ff @(posedge i_clk) begin
            if (adv && sfx_we && r_len == LEN_W'(g)) begin
                r_sfx[g] <= folded;
            end
        end
    end

    // suffix decode: b, or k/m/g followed by optional i and optional b
    always_comb begin
        dec_ok    = 1'b0;
        dec_steps = '0;
        dec_bin   = 1'b0;
        if (r_len == '0) begin
            dec_ok = 1'b1;
        end else if (r_len == LEN_W'(1) && r_sfx[0] == CH_B) begin
            dec_ok = 1'b1;
        end else begin
            case (r_sfx[0])
                CH_K:    dec_steps = STEP_W'(1);
                CH_M:    dec_steps = STEP_W'(2);
                CH_G:    dec_steps = STEP_W'(3);
                default: dec_steps = '0;
            endcase
            if (dec_steps != '0) begin
                if (r_len == LEN_W'(1)) begin
                    dec_ok = 1'b1;
                end else if (r_len == LEN_W'(2)) begin
                    dec_ok  = (r_sfx[1] == CH_I) || (r_sfx[1] == CH_B);
                    dec_bin = (r_sfx[1] == CH_I);
                end else if (r_len == LEN_W'(3)) begin
                    dec_ok  = (r_sfx[1] == CH_I) && (r_sfx[2] == CH_B);
                    dec_bin = 1'b1;
                end
            end
        end
    end

    assign o_ctl.ok    = r_seen && !r_failed && dec_ok;
    assign o_ctl.steps = dec_steps;
    assign o_ctl.bin   = dec_bin;
    assign o_value     = r_acc;

endmodule

// ----- design/swsp_mul_stage.sv -----
// One multiply stage: scales the value by 1000 or 1024 while steps remain,
// with overflow detection. Depends on swsp_pkg.
module swsp_mul_stage #(
    parameter int VALUE_WIDTH = swsp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  swsp_pkg::t_mul_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output swsp_pkg::t_mul_ctl     o_ctl,
    output logic [VALUE_WIDTH-1:0] o_value
);
    import swsp_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + 10;

    logic                   r_valid;
    t_mul_ctl               r_ctl, n_ctl;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [PROD_W-1:0]      wide;
    logic [PROD_W-1:0]      prod;

    assign o_ready = !r_valid || i_ready;

    assign wide = {10'b0, i_value};
    // x * 1000 = x * 1024 - x * 16 - x * 8
    assign prod = i_ctl.bin ? (wide << 10) : (wide << 10) - (wide << 4) - (wide << 3);

    always_comb begin
        n_ctl   = i_ctl;
        n_value = i_value;
        if (i_ctl.ok && i_ctl.steps != '0) begin
            n_ctl.steps = i_ctl.steps - 1'b1;
            n_ctl.ok    = ~|prod[PROD_W-1:VALUE_WIDTH];
            n_value     = prod[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl   <= n_ctl;
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_value = r_value;

endmodule
